FILE: rtl/core/hbsc_pkg.sv
// Shared types, constants and frame functions for the Hamming byte-stream codec.
package hbsc_pkg;

  localparam int OFFSET_BITS_DEFAULT = 32;
  localparam int FRAME_BITS = 40;
  localparam int WORD_BITS = 32;
  localparam int MAX_RESULTS = 5;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] offset;
  } result_t;

  function automatic logic is_data_pos(input int p);
    logic pow2;
    pow2 = (p != 0) && ((p & (p - 1)) == 0);
    return (p >= 3) && (p <= 38) && !pow2;
  endfunction

  function automatic logic [FRAME_BITS-1:0] build_frame(input logic [WORD_BITS-1:0] w);
    logic [FRAME_BITS-1:0] f;
    logic par;
    int k;
    f = '0;
    k = WORD_BITS;
    for (int p = 3; p <= 38; p++) begin
      if (is_data_pos(p)) begin
        k = k - 1;
        f[FRAME_BITS-1-p] = w[k];
      end
    end
    for (int q = 1; q <= 32; q = q * 2) begin
      par = 1'b0;
      for (int p = 0; p < FRAME_BITS; p++) begin
        if ((p & q) != 0) begin
          par = par ^ f[FRAME_BITS-1-p];
        end
      end
      f[FRAME_BITS-1-q] = par;
    end
    return f;
  endfunction

  function automatic logic [5:0] syndrome(input logic [FRAME_BITS-1:0] f);
    logic [5:0] s;
    s = '0;
    for (int p = 0; p < FRAME_BITS; p++) begin
      if (f[FRAME_BITS-1-p]) begin
        s = s ^ 6'(p);
      end
    end
    return s;
  endfunction

  function automatic logic [FRAME_BITS-1:0] flip_mask(input logic [5:0] s);
    logic [FRAME_BITS-1:0] m;
    m = '0;
    for (int p = 1; p < FRAME_BITS; p++) begin
      m[FRAME_BITS-1-p] = (s == 6'(p));
    end
    return m;
  endfunction

  function automatic logic [WORD_BITS-1:0] extract_data(input logic [FRAME_BITS-1:0] f);
    logic [WORD_BITS-1:0] w;
    int k;
    w = '0;
    k = WORD_BITS;
    for (int p = 3; p <= 38; p++) begin
      if (is_data_pos(p)) begin
        k = k - 1;
        w[k] = f[FRAME_BITS-1-p];
      end
    end
    return w;
  endfunction

endpackage

FILE: rtl/core/hbsc_if.sv
// Handshake interfaces for the input, result and configuration channels.
interface hbsc_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       byte_present;
  logic       stream_end;

  modport source (output valid, in_byte, byte_present, stream_end, input ready);
  modport sink (input valid, in_byte, byte_present, stream_end, output ready);
endinterface

interface hbsc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [31:0] error_offset;
  logic        run_last;

  modport source (output valid, kind, out_byte, error_offset, run_last, input ready);
  modport sink (input valid, kind, out_byte, error_offset, run_last, output ready);
endinterface

interface hbsc_cfg_if;
  logic valid;
  logic ready;
  logic mode;

  modport source (output valid, mode, input ready);
  modport sink (input valid, mode, output ready);
endinterface

FILE: rtl/core/hamming_byte_stream_codec.sv
// Top level of the Hamming byte-stream codec: input register, frame logic, result shift line.
// An input transfer is registered; once the result shift line is empty or its last result is
// transferring, the item's results are registered from the input register into the shift line.
// Results leave at one per cycle while the result sink is ready, so an item with up to five
// results holds the next item in the input register until its last result transfers.
// Throughput is set by the result shift line.
// Reset is synchronous and clears mode, gathered bytes, the byte count and the halt flag.
module hamming_byte_stream_codec #(
  parameter int OFFSET_BITS = hbsc_pkg::OFFSET_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  hbsc_item_if.sink     item,
  hbsc_result_if.source result,
  hbsc_cfg_if.sink      cfg
);

  logic                                mode;
  logic [hbsc_pkg::FRAME_BITS-1:0]     gather;
  logic [2:0]                          gather_cnt;
  logic [OFFSET_BITS-1:0]              processed;
  logic                                halted;

  logic                                item_valid;
  logic [7:0]                          item_byte;
  logic                                item_present;
  logic                                item_end;

  hbsc_pkg::result_t                   ent [hbsc_pkg::MAX_RESULTS];
  logic [2:0]                          rem;

  logic                                load;
  logic                                out_xfer;

  logic                                act;
  logic [hbsc_pkg::FRAME_BITS-1:0]     g1;
  logic [2:0]                          c1;
  logic                                hdr_bad;
  logic                                enc_full;
  logic                                dec_full;
  logic [5:0]                          syn;
  logic                                syn_bad;
  logic [hbsc_pkg::WORD_BITS-1:0]      enc_word;
  logic [hbsc_pkg::FRAME_BITS-1:0]     enc_frame;
  logic [hbsc_pkg::WORD_BITS-1:0]      dec_word;
  logic                                do_enc;
  logic                                do_dec;
  logic                                fail;
  logic                                report;

  logic [OFFSET_BITS:0]                off_sum;
  logic [OFFSET_BITS-1:0]              off_sat;
  logic [31:0]                         off32;
  logic [OFFSET_BITS:0]                proc_sum;
  logic [OFFSET_BITS-1:0]              proc_sat;

  hbsc_pkg::result_t                   res_next [hbsc_pkg::MAX_RESULTS];
  logic [2:0]                          n_next;
  logic [hbsc_pkg::FRAME_BITS-1:0]     gather_next;
  logic [2:0]                          gather_cnt_next;
  logic [OFFSET_BITS-1:0]              processed_next;
  logic                                halted_next;

  assign out_xfer = result.valid && result.ready;
  assign load = item_valid && ((rem == 3'd0) || (out_xfer && (rem == 3'd1)));
  assign item.ready = !item_valid || load;
  assign cfg.ready = 1'b1;

  assign result.valid = (rem != 3'd0);
  assign result.kind = ent[0].kind;
  assign result.out_byte = ent[0].data;
  assign result.error_offset = ent[0].offset;
  assign result.run_last = (rem == 3'd1);

  assign off_sum = {1'b0, processed} + (OFFSET_BITS + 1)'(syn[5:3]);
  assign off_sat = off_sum[OFFSET_BITS] ? '1 : off_sum[OFFSET_BITS-1:0];
  assign proc_sum = {1'b0, processed} + (OFFSET_BITS + 1)'(5);
  assign proc_sat = proc_sum[OFFSET_BITS] ? '1 : proc_sum[OFFSET_BITS-1:0];

  generate
    if (OFFSET_BITS > 32) begin : g_off_wide
      assign off32 = (|off_sat[OFFSET_BITS-1:32]) ? 32'hFFFF_FFFF : off_sat[31:0];
    end else begin : g_off_narrow
      assign off32 = 32'(off_sat);
    end
  endgenerate

  always_comb begin
    act = item_valid && !halted;
    g1 = item_present ? {gather[31:0], item_byte} : gather;
    c1 = item_present ? gather_cnt + 3'd1 : gather_cnt;
    hdr_bad = (mode == hbsc_pkg::MODE_DECODE) && item_present &&
              (((gather_cnt == 3'd0) && item_byte[7]) ||
               ((gather_cnt == 3'd4) && item_byte[0]));
    enc_full = (mode == hbsc_pkg::MODE_ENCODE) && item_present && (c1 == 3'd4);
    dec_full = (mode == hbsc_pkg::MODE_DECODE) && item_present && (c1 == 3'd5);
    syn = hbsc_pkg::syndrome(g1);
    syn_bad = syn[5] && (syn[4] || syn[3]);
    case (c1)
      3'd1:    enc_word = {g1[7:0], 24'h0};
      3'd2:    enc_word = {g1[15:0], 16'h0};
      3'd3:    enc_word = {g1[23:0], 8'h0};
      default: enc_word = g1[31:0];
    endcase
    enc_frame = hbsc_pkg::build_frame(enc_word);
    dec_word = hbsc_pkg::extract_data(g1 ^ hbsc_pkg::flip_mask(syn));

    do_enc = act && (mode == hbsc_pkg::MODE_ENCODE) &&
             (enc_full || (item_end && (c1 != 3'd0)));
    fail = act && (mode == hbsc_pkg::MODE_DECODE) &&
           (hdr_bad || (dec_full && syn_bad) || (!dec_full && item_end && (c1 != 3'd0)));
    do_dec = act && dec_full && !hdr_bad && !syn_bad;
    report = do_dec && (syn != 6'd0);

    for (int i = 0; i < hbsc_pkg::MAX_RESULTS; i++) begin
      res_next[i] = '{kind: hbsc_pkg::KIND_DATA, data: 8'h0, offset: 32'h0};
    end
    n_next = 3'd0;
    if (do_enc) begin
      for (int i = 0; i < hbsc_pkg::MAX_RESULTS; i++) begin
        res_next[i].data = enc_frame[hbsc_pkg::FRAME_BITS-1-8*i -: 8];
      end
      n_next = 3'd5;
    end else if (fail) begin
      res_next[0].kind = hbsc_pkg::KIND_FAIL;
      n_next = 3'd1;
    end else if (do_dec) begin
      if (report) begin
        res_next[0].kind = hbsc_pkg::KIND_REPORT;
        res_next[0].offset = off32;
        for (int i = 0; i < 4; i++) begin
          res_next[i+1].data = dec_word[hbsc_pkg::WORD_BITS-1-8*i -: 8];
        end
        n_next = 3'd5;
      end else begin
        for (int i = 0; i < 4; i++) begin
          res_next[i].data = dec_word[hbsc_pkg::WORD_BITS-1-8*i -: 8];
        end
        n_next = 3'd4;
      end
    end

    gather_next = gather;
    gather_cnt_next = gather_cnt;
    processed_next = processed;
    halted_next = halted || fail;
    if (act) begin
      if (do_enc || do_dec || fail || item_end) begin
        gather_next = '0;
        gather_cnt_next = 3'd0;
      end else begin
        gather_next = g1;
        gather_cnt_next = c1;
      end
      if (!fail) begin
        if (item_end) begin
          processed_next = '0;
        end else if (do_dec) begin
          processed_next = proc_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= hbsc_pkg::MODE_ENCODE;
      gather <= '0;
      gather_cnt <= 3'd0;
      processed <= '0;
      halted <= 1'b0;
      item_valid <= 1'b0;
      rem <= 3'd0;
    end else begin
      if (item.valid && item.ready) begin
        item_valid <= 1'b1;
        item_byte <= item.in_byte;
        item_present <= item.byte_present;
        item_end <= item.stream_end;
      end else if (load) begin
        item_valid <= 1'b0;
      end
      if (load) begin
        gather <= gather_next;
        gather_cnt <= gather_cnt_next;
        processed <= processed_next;
        halted <= halted_next;
        rem <= n_next;
        for (int i = 0; i < hbsc_pkg::MAX_RESULTS; i++) begin
          ent[i] <= res_next[i];
        end
      end else if (out_xfer) begin
        rem <= rem - 3'd1;
        for (int i = 0; i < hbsc_pkg::MAX_RESULTS - 1; i++) begin
          ent[i] <= ent[i+1];
        end
      end
      if (cfg.valid && cfg.ready) begin
        mode <= cfg.mode;
        gather <= '0;
        gather_cnt <= 3'd0;
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) rem <= 3'd5)
    else $error("Result count exceeds five.");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) gather_cnt <= 3'd4)
    else $error("Gathered byte count exceeds four.");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("Halt flag cleared without reset.");
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.kind == hbsc_pkg::KIND_FAIL) |-> result.run_last)
    else $error("Codeword error is not the last result of its item.");
  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.kind != hbsc_pkg::KIND_REPORT) |-> (result.error_offset == 32'h0))
    else $error("Nonzero offset on a result that is not an error report.");
`endif

endmodule

FILE: bench/tb_hamming_byte_stream_codec.sv
// Self-checking testbench for the Hamming byte-stream codec with its own frame predictor.
module tb_hamming_byte_stream_codec;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 310;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] offset;
    logic        last;
  } codec_result_t;

  logic clk = 1'b0;
  logic rst;

  hbsc_item_if item_ch ();
  hbsc_result_if result_ch ();
  hbsc_cfg_if cfg_ch ();

  hamming_byte_stream_codec DUT (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic          cur_mode = hbsc_pkg::MODE_ENCODE;
  logic [39:0]   gather_bytes = '0;
  logic [2:0]    gather_count = '0;
  logic [31:0]   decoded_bytes = '0;
  logic          codec_halted = 1'b0;
  codec_result_t step_out[$];
  codec_result_t due_results[$];

  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   fed_items = 0;
  logic calm = 1'b0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  function automatic bit payload_slot(input int p);
    return p >= 3 && p <= 38 && (p & (p - 1)) != 0;
  endfunction

  function automatic logic [5:0] position_xor(input logic [39:0] f);
    logic [5:0] s;
    s = '0;
    for (int p = 0; p < 40; p++) begin
      if (f[39 - p]) s = s ^ 6'(p);
    end
    return s;
  endfunction

  function automatic logic [39:0] hamming_frame_of(input logic [31:0] w);
    logic [39:0] f;
    logic [5:0]  s;
    int          k;
    f = '0;
    k = 31;
    for (int p = 3; p <= 38; p++) begin
      if (payload_slot(p)) begin
        f[39 - p] = w[k];
        k--;
      end
    end
    // Setting each check bit to the matching syndrome bit brings the syndrome to zero.
    s = position_xor(f);
    for (int q = 0; q < 6; q++) f[39 - (1 << q)] = s[q];
    return f;
  endfunction

  function automatic logic [31:0] frame_payload(input logic [39:0] f);
    logic [31:0] w;
    w = '0;
    for (int p = 3; p <= 38; p++) begin
      if (payload_slot(p)) w = {w[30:0], f[39 - p]};
    end
    return w;
  endfunction

  function automatic void emit(input logic [1:0] kind, input logic [7:0] data,
                               input logic [31:0] offset);
    codec_result_t r;
    r.kind = kind;
    r.data = data;
    r.offset = offset;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void enter_halt();
    emit(hbsc_pkg::KIND_FAIL, 8'h00, 32'h0);
    codec_halted = 1'b1;
    gather_bytes = '0;
    gather_count = '0;
  endfunction

  function automatic void emit_codeword();
    logic [39:0] shifted;
    logic [39:0] f;
    shifted = gather_bytes << (8 * (4 - int'(gather_count)));
    f = hamming_frame_of(shifted[31:0]);
    for (int i = 0; i < 5; i++) emit(hbsc_pkg::KIND_DATA, f[39 - 8 * i -: 8], 32'h0);
    gather_bytes = '0;
    gather_count = '0;
  endfunction

  function automatic void emit_payload();
    logic [39:0] f;
    logic [5:0]  s;
    logic [32:0] sum;
    logic [31:0] w;
    f = gather_bytes;
    s = position_xor(f);
    if (s >= 6'd40) begin
      enter_halt();
      return;
    end
    if (s != 6'd0) begin
      sum = {1'b0, decoded_bytes} + 33'(s / 8);
      emit(hbsc_pkg::KIND_REPORT, 8'h00, sum[32] ? 32'hFFFF_FFFF : sum[31:0]);
      f[39 - s] = ~f[39 - s];
    end
    w = frame_payload(f);
    for (int i = 0; i < 4; i++) emit(hbsc_pkg::KIND_DATA, w[31 - 8 * i -: 8], 32'h0);
    sum = {1'b0, decoded_bytes} + 33'd5;
    decoded_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    gather_bytes = '0;
    gather_count = '0;
  endfunction

  function automatic void advance_codec(input logic [7:0] b, input logic present,
                                        input logic fin);
    codec_result_t tail;
    step_out.delete();
    if (codec_halted) return;
    if (present) begin
      if (cur_mode == hbsc_pkg::MODE_ENCODE) begin
        gather_bytes = {gather_bytes[31:0], b};
        gather_count++;
        if (gather_count >= 3'd4) emit_codeword();
      end else if ((gather_count == 3'd0 && b[7]) || (gather_count == 3'd4 && b[0])) begin
        enter_halt();
      end else begin
        gather_bytes = {gather_bytes[31:0], b};
        gather_count++;
        if (gather_count >= 3'd5) emit_payload();
      end
    end
    if (fin && !codec_halted) begin
      if (gather_count != 3'd0) begin
        if (cur_mode == hbsc_pkg::MODE_ENCODE) emit_codeword();
        else enter_halt();
      end
      if (!codec_halted) begin
        gather_bytes = '0;
        gather_count = '0;
        decoded_bytes = '0;
      end
    end
    if (step_out.size() != 0) begin
      tail = step_out.pop_back();
      tail.last = 1'b1;
      step_out.push_back(tail);
    end
    foreach (step_out[i]) due_results.push_back(step_out[i]);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    codec_result_t want;
    if (rst !== 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d byte %0h offset %0h",
                 $time, result_ch.kind, result_ch.out_byte, result_ch.error_offset);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(result_ch.kind));
        check_field("out_byte", 32'(want.data), 32'(result_ch.out_byte));
        check_field("error_offset", want.offset, result_ch.error_offset);
        check_field("run_last", 32'(want.last), 32'(result_ch.run_last));
      end
    end
    result_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 19);
  end

  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic present, input logic fin);
    while (!calm && $urandom_range(99) < 19) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.in_byte <= b;
    item_ch.byte_present <= present;
    item_ch.stream_end <= fin;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    advance_codec(b, present, fin);
    if (present || fin) fed_items++;
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.mode <= m;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_mode = m;
    gather_bytes = '0;
    gather_count = '0;
  endtask

  task automatic send_frame(input logic [39:0] f, input logic end_on_last, input bit sprinkle);
    for (int i = 0; i < 5; i++) begin
      if (sprinkle && $urandom_range(99) < 8) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(f[39 - 8 * i -: 8], 1'b1, end_on_last && i == 4);
    end
  endtask

  function automatic logic [39:0] flip_pair(input logic [39:0] f, input bit want_bad);
    int p1;
    int p2;
    do begin
      p1 = $urandom_range(1, 38);
      p2 = $urandom_range(1, 38);
    end while (p1 == p2 || (((p1 ^ p2) >= 40) != want_bad));
    f[39 - p1] = ~f[39 - p1];
    f[39 - p2] = ~f[39 - p2];
    return f;
  endfunction

  function automatic logic [39:0] pick_codeword();
    logic [31:0] w;
    logic [39:0] f;
    int          r;
    w = $urandom;
    if ($urandom_range(15) == 0) w = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
    f = hamming_frame_of(w);
    r = $urandom_range(99);
    if (r >= 80) begin
      f = flip_pair(f, 1'b0);
    end else if (r >= 35) begin
      r = $urandom_range(1, 38);
      f[39 - r] = ~f[39 - r];
    end
    return f;
  endfunction

  task automatic test_encode_corners();
    write_mode(hbsc_pkg::MODE_ENCODE);
    for (int i = 0; i < 4; i++) send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b1);
    send_item(8'hC3, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_decode_corners();
    logic [39:0] f;
    write_mode(hbsc_pkg::MODE_DECODE);
    send_frame(hamming_frame_of(32'hFFFF_FFFF), 1'b0, 1'b0);
    f = hamming_frame_of(32'h0000_0000);
    f[1] = ~f[1];
    send_frame(f, 1'b0, 1'b0);
    // Flipping the first check position and the last data position gives the highest
    // defined syndrome.
    f = hamming_frame_of(32'h1234_5678);
    f[38] = ~f[38];
    f[1] = ~f[1];
    send_frame(f, 1'b1, 1'b0);
  endtask

  task automatic test_backpressure();
    write_mode(hbsc_pkg::MODE_ENCODE);
    calm <= 1'b1;
    for (int i = 0; i < 40; i++) send_item(8'($urandom), 1'b1, 1'b0);
    hold_toggle <= ~hold_toggle;
    for (int i = 0; i < 40; i++) send_item(8'($urandom), 1'b1, i == 39);
    drain_results();
    calm <= 1'b0;
  endtask

  task automatic test_random_streams();
    int first;
    int n;
    int r;
    logic [39:0] f;
    first = fed_items;
    while (fed_items - first < RANDOM_ITEMS) begin
      if ($urandom_range(1) == 0) begin
        write_mode(hbsc_pkg::MODE_ENCODE);
        n = $urandom_range(20, 60);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(99);
          if (r < 8) send_item(8'($urandom), 1'b0, 1'b0);
          else if (r < 14) send_item(8'($urandom), 1'b0, 1'b1);
          else send_item(8'($urandom), 1'b1, $urandom_range(99) < 10);
        end
      end else begin
        write_mode(hbsc_pkg::MODE_DECODE);
        n = $urandom_range(4, 12);
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(99);
          send_frame(pick_codeword(), r < 15, 1'b1);
          if (r >= 15 && $urandom_range(99) < 10) send_item(8'($urandom), 1'b0, 1'b1);
        end
        // A partial frame left behind is dropped by the next mode write.
        if ($urandom_range(99) < 30) begin
          f = pick_codeword();
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) send_item(f[39 - 8 * i -: 8], 1'b1, 1'b0);
        end
      end
    end
  endtask

  task automatic test_halt();
    logic [39:0] f;
    int n;
    write_mode(hbsc_pkg::MODE_DECODE);
    send_frame(pick_codeword(), 1'b0, 1'b0);
    f = hamming_frame_of($urandom);
    case ($urandom_range(3))
      0: send_item(8'h80 | 8'($urandom), 1'b1, 1'b0);
      1: begin
        for (int i = 0; i < 4; i++) send_item(f[39 - 8 * i -: 8], 1'b1, 1'b0);
        send_item(f[7:0] | 8'h01, 1'b1, 1'b0);
      end
      2: send_frame(flip_pair(f, 1'b1), 1'b0, 1'b0);
      default: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_item(f[39 - 8 * i -: 8], 1'b1, 1'b0);
        send_item(8'($urandom), 1'b0, 1'b1);
      end
    endcase
    for (int i = 0; i < 10; i++) send_item(8'($urandom), 1'($urandom), 1'($urandom));
    write_mode(hbsc_pkg::MODE_ENCODE);
    for (int i = 0; i < 8; i++) send_item(8'($urandom), 1'b1, i == 7);
  endtask

  initial begin
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.in_byte <= 8'h00;
    item_ch.byte_present <= 1'b0;
    item_ch.stream_end <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.mode <= hbsc_pkg::MODE_ENCODE;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_encode_corners();
    test_decode_corners();
    test_backpressure();
    test_random_streams();
    test_halt();
    drain_results();
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
